### rtl/circular_deque_assert.svh
// Assertion helpers for the circular deque. Bodies vanish under SYNTHESIS.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define CDQ_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// ante in a cycle implies cons in the same cycle
`define CDQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante in a cycle implies cons in the next cycle
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CDQ_ASSERT_HOLDS(lbl, expr, msg)
`define CDQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [1:0]               req_t;
  typedef logic [1:0]               status_t;
  typedef logic [OCC_W-1:0]         occ_t;

  // request codes
  localparam req_t REQ_PUSH_FRONT = 2'd0;
  localparam req_t REQ_PUSH_BACK  = 2'd1;
  localparam req_t REQ_POP_FRONT  = 2'd2;
  localparam req_t REQ_POP_BACK   = 2'd3;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // what every cell of a chain does at a clock edge
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,  // shift toward the tail, new item enters cell 0
    OP_REMOVE = 3'd2,  // shift toward cell 0, cell 0 item leaves
    OP_APPEND = 3'd3,  // first empty cell takes the new item
    OP_TRIM   = 3'd4   // last occupied cell drops its item
  } cell_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic  valid;
    word_t data;
  } link_t;

  typedef struct packed {
    word_t   pop_value;
    status_t status;
    occ_t    occupancy;
  } rsp_t;

endpackage

### rtl/cdq_if.sv
interface cdq_in_if;
  logic                 valid;
  logic                 ready;
  cdq_pkg::req_t        req_type;
  cdq_pkg::word_t       push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_out_if;
  logic                 valid;
  logic                 ready;
  cdq_pkg::word_t       pop_value;
  cdq_pkg::status_t     status;
  cdq_pkg::occ_t        occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

### rtl/cdq_cell.sv
// One storage cell: holds one entry and trades it with its neighbors.
module cdq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_pkg::cell_op_t op,
  input  cdq_pkg::word_t    din,
  input  cdq_pkg::link_t    from_left,
  input  cdq_pkg::link_t    from_right,
  output cdq_pkg::link_t    link
);

  logic           valid_r, valid_nxt;
  cdq_pkg::word_t data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    case (op)
      cdq_pkg::OP_INSERT: begin
        valid_nxt = from_left.valid;
        data_nxt  = from_left.data;
      end
      cdq_pkg::OP_REMOVE: begin
        valid_nxt = from_right.valid;
        data_nxt  = from_right.data;
      end
      cdq_pkg::OP_APPEND: begin
        if (!valid_r && from_left.valid) begin
          valid_nxt = 1'b1;
          data_nxt  = din;
        end
      end
      cdq_pkg::OP_TRIM: begin
        if (valid_r && !from_right.valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
        valid_nxt = valid_r;
        data_nxt  = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link.valid = valid_r;
  assign link.data  = data_r;

endmodule

### rtl/cdq_chain.sv
// Row of cells kept packed toward cell 0; cell 0 is the near end.
module cdq_chain #(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_pkg::cell_op_t op,
  input  cdq_pkg::word_t    din,
  output cdq_pkg::link_t    head,
  output logic              full
);

  cdq_pkg::link_t lnk [DEPTH];
  cdq_pkg::link_t near_edge;
  cdq_pkg::link_t far_edge;

  // new item enters at cell 0; nothing lies past the last cell
  assign near_edge.valid = 1'b1;
  assign near_edge.data  = din;
  assign far_edge.valid  = 1'b0;
  assign far_edge.data   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdq_pkg::link_t left_l;
    cdq_pkg::link_t right_l;

    if (i == 0) begin : g_first
      assign left_l = near_edge;
    end else begin : g_mid_l
      assign left_l = lnk[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_l = far_edge;
    end else begin : g_mid_r
      assign right_l = lnk[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .din        (din),
      .from_left  (left_l),
      .from_right (right_l),
      .link       (lnk[i])
    );
  end

  assign head = lnk[0];
  assign full = lnk[DEPTH-1].valid;

endmodule

### rtl/circular_deque.sv
// Channel | Dir | Handshake     | Payload
// --------+-----+---------------+----------------------------------------------------
// in_req  | in  | valid / ready | req_type[1:0], push_value[31:0] signed
// out_rsp | out | valid / ready | pop_value[31:0] signed, status[1:0], occupancy[3:0]
//
// One item per cycle while the skid entry is free (in_req.ready high); the result
// is registered, in the result register or, while a result waits, in the skid.
// Reset (rst_n low, synchronous) empties the queue.
// A two-entry output buffer (result register plus skid) lets an item be taken
// while a result waits; in_req.ready drops only when both entries are full.
//
// Storage is two rows of DEPTH cells holding the same entries in opposite
// order: the front row has the front entry in cell 0, the back row the back
// entry. Every pop then reads cell 0 of one row; the row being popped shifts
// toward cell 0 while the other row drops its last occupied cell. Pushes
// shift a new item into one row and append it after the last entry of the
// other. Each cell only looks at its two neighbors, so no wide read mux and
// no pointers are needed; the occupancy is kept in a separate counter.
// Occupancy reports the low four bits of the count.
module circular_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  cdq_in_if.sink           in_req,
  cdq_out_if.source        out_rsp
);

`include "circular_deque_assert.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  // occupancy counter
  logic [CW-1:0] fill_r, fill_nxt;

  // output buffer
  logic          out_vld_r, out_vld_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  cdq_pkg::rsp_t out_r, out_nxt;
  cdq_pkg::rsp_t skid_r, skid_nxt;

  logic              in_fire;
  logic              out_fire;
  cdq_pkg::cell_op_t op_front, op_back;
  cdq_pkg::cell_op_t op_front_q, op_back_q;
  cdq_pkg::link_t    front_head, back_head;
  logic              front_full, back_full;
  logic              is_empty, is_full;
  cdq_pkg::rsp_t     rsp;
  logic [CW-1:0]     cnt_after;

  assign in_req.ready = !skid_vld_r;
  assign in_fire      = in_req.valid && !skid_vld_r;
  assign out_fire     = out_vld_r && out_rsp.ready;

  assign is_empty = (fill_r == '0);
  assign is_full  = (fill_r == FULL_CNT);

  // decode the request against the current occupancy
  always_comb begin
    op_front      = cdq_pkg::OP_HOLD;
    op_back       = cdq_pkg::OP_HOLD;
    rsp.pop_value = '0;
    rsp.status    = cdq_pkg::ST_OK;
    cnt_after     = fill_r;
    case (in_req.req_type)
      cdq_pkg::REQ_PUSH_FRONT: begin
        if (is_full) begin
          rsp.status = cdq_pkg::ST_FULL;
        end else begin
          op_front  = cdq_pkg::OP_INSERT;
          op_back   = cdq_pkg::OP_APPEND;
          cnt_after = fill_r + ONE_CNT;
        end
      end
      cdq_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          rsp.status = cdq_pkg::ST_FULL;
        end else begin
          op_front  = cdq_pkg::OP_APPEND;
          op_back   = cdq_pkg::OP_INSERT;
          cnt_after = fill_r + ONE_CNT;
        end
      end
      cdq_pkg::REQ_POP_FRONT: begin
        if (is_empty) begin
          rsp.status = cdq_pkg::ST_EMPTY;
        end else begin
          op_front      = cdq_pkg::OP_REMOVE;
          op_back       = cdq_pkg::OP_TRIM;
          rsp.pop_value = front_head.data;
          cnt_after     = fill_r - ONE_CNT;
        end
      end
      cdq_pkg::REQ_POP_BACK: begin
        if (is_empty) begin
          rsp.status = cdq_pkg::ST_EMPTY;
        end else begin
          op_front      = cdq_pkg::OP_TRIM;
          op_back       = cdq_pkg::OP_REMOVE;
          rsp.pop_value = back_head.data;
          cnt_after     = fill_r - ONE_CNT;
        end
      end
      default: begin
        rsp.status = cdq_pkg::ST_OK;
      end
    endcase
    rsp.occupancy = cdq_pkg::occ_t'(cnt_after);
  end

  // rows only move on a taken item
  assign op_front_q = in_fire ? op_front : cdq_pkg::OP_HOLD;
  assign op_back_q  = in_fire ? op_back  : cdq_pkg::OP_HOLD;
  assign fill_nxt   = in_fire ? cnt_after : fill_r;

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op_front_q),
    .din   (in_req.push_value),
    .head  (front_head),
    .full  (front_full)
  );

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op_back_q),
    .din   (in_req.push_value),
    .head  (back_head),
    .full  (back_full)
  );

  // output buffer: result register fed by the new item or the skid entry
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_fire) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;   // ready was low, so no new item this cycle
      end else begin
        out_nxt     = rsp;
        out_vld_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_nxt     = rsp;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.pop_value = out_r.pop_value;
  assign out_rsp.status    = out_r.status;
  assign out_rsp.occupancy = out_r.occupancy;

  // both rows and the counter agree on empty and full
  `CDQ_ASSERT_HOLDS(a_empty, {front_head.valid, back_head.valid} == {2{!is_empty}}, "head valid")
  `CDQ_ASSERT_HOLDS(a_full, {front_full, back_full} == {2{is_full}}, "tail valid")
  // with one entry the front and back are the same item
  `CDQ_ASSERT_IMPLY(a_single, fill_r == ONE_CNT, front_head.data == back_head.data, "one entry")
  // skid entry only exists behind a waiting result
  `CDQ_ASSERT_IMPLY(a_skid_order, skid_vld_r, out_vld_r, "skid entry without result entry")
  // a refused request leaves the count alone
  `CDQ_ASSERT_NEXT(a_refuse, in_fire && rsp.status != cdq_pkg::ST_OK, $stable(fill_r), "count")

endmodule

### verif/tb_top.sv
module tb_top;

  localparam int unsigned DQ_DEPTH    = 8;
  localparam int          N_RANDOM    = 1150;
  localparam int          IDLE_PCT    = 12;
  localparam int          HOLD_AT     = 250;   // items taken before the long output stall
  localparam int          HOLD_CYCLES = 60;
  localparam int          QUIET_LO    = 450;   // no idling on either side in this item window
  localparam int          QUIET_HI    = 650;
  localparam int          DRAIN_AT    = 800;   // random item that waits for a fully drained block
  localparam int          STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int          MAX_REPORTS = 10;

  typedef struct {
    cdq_pkg::req_t  req;
    cdq_pkg::word_t value;
    bit             wait_drain;  // hold this item back until every result is in
  } pend_item_t;

  logic clk = 1'b0;
  logic rst_n;

  cdq_in_if  req_ch ();
  cdq_out_if rsp_ch ();

  circular_deque #(.DEPTH(DQ_DEPTH)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  pend_item_t    pending [$];
  cdq_pkg::rsp_t expected_rsp [$];
  int            in_count    = 0;  // items taken, updated at the clock edge
  int            out_count   = 0;  // results taken
  int            total_items = 0;
  int            mismatches  = 0;
  int            idle_cycles = 0;
  int            hold_left   = 0;
  bit            hold_done   = 1'b0;

  wire quiet = (in_count >= QUIET_LO) && (in_count < QUIET_HI);

  // ---------------------------------------------------------------------------
  // Deque shadow: head points at the front entry, tail one past the back entry.
  // Slots outside the occupied region are never read, so no reset is needed.
  // ---------------------------------------------------------------------------
  cdq_pkg::word_t shadow_slots [DQ_DEPTH];
  int             front_ptr = 0;
  int             back_ptr  = 0;
  int             held      = 0;

  function automatic cdq_pkg::rsp_t deque_apply(cdq_pkg::req_t req, cdq_pkg::word_t value);
    cdq_pkg::rsp_t r;
    r.pop_value = '0;
    r.status    = cdq_pkg::ST_OK;
    case (req)
      cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK: begin
        if (held == DQ_DEPTH) begin
          r.status = cdq_pkg::ST_FULL;
        end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
          // front push at slot 0 wraps the head to the last slot
          front_ptr = (front_ptr == 0) ? DQ_DEPTH - 1 : front_ptr - 1;
          shadow_slots[front_ptr] = value;
          held++;
        end else begin
          // back push into the last slot wraps the tail to slot 0
          shadow_slots[back_ptr] = value;
          back_ptr = (back_ptr + 1) % DQ_DEPTH;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = cdq_pkg::ST_EMPTY;
        end else if (req == cdq_pkg::REQ_POP_FRONT) begin
          r.pop_value = shadow_slots[front_ptr];
          front_ptr = (front_ptr + 1) % DQ_DEPTH;
          held--;
        end else begin
          // back pop with the tail at slot 0 takes the last slot
          back_ptr = (back_ptr == 0) ? DQ_DEPTH - 1 : back_ptr - 1;
          r.pop_value = shadow_slots[back_ptr];
          held--;
        end
      end
    endcase
    r.occupancy = cdq_pkg::occ_t'(held);
    return r;
  endfunction

  function automatic cdq_pkg::word_t pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input cdq_pkg::req_t req, input cdq_pkg::word_t value,
                         input bit wait_drain);
    pend_item_t it;
    it.req        = req;
    it.value      = value;
    it.wait_drain = wait_drain;
    pending.push_back(it);
    total_items++;
  endtask

  task automatic report_mismatch(input string what, input cdq_pkg::rsp_t want,
                                 input cdq_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("result %0d: %s: want value %h status %0d occ %0d, got %h %0d %0d",
               out_count, what, want.pop_value, want.status, want.occupancy,
               got.pop_value, got.status, got.occupancy);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. An item is predicted at the edge where it is taken; the
  // next one goes out when the bus is free, unless a random gap is drawn or
  // the item must wait until the block has handed back every result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_drive
    logic took;
    pend_item_t it;
    if (!rst_n) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= cdq_pkg::REQ_PUSH_FRONT;
      req_ch.push_value <= '0;
    end else begin
      took = req_ch.valid && req_ch.ready;
      if (took) begin
        expected_rsp.push_back(deque_apply(req_ch.req_type, req_ch.push_value));
        in_count <= in_count + 1;
      end
      if (!req_ch.valid || took) begin
        if (pending.size() == 0 || (!quiet && $urandom_range(99) < IDLE_PCT)) begin
          req_ch.valid <= 1'b0;
        end else if (pending[0].wait_drain && out_count != in_count + int'(took)) begin
          // out_count does not yet hold a result taken at this edge, so the pause may run on
          req_ch.valid <= 1'b0;
        end else begin
          it = pending.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= it.req;
          req_ch.push_value <= it.value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready. Random stalls, plus one long hold-off once enough items have
  // gone in: the sender keeps offering, so the output buffer fills and the
  // block must drop its input ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_ready
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      hold_done    <= 1'b1;
    end else begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: every taken result against the oldest prediction.
  always @(posedge clk) begin : rsp_check
    cdq_pkg::rsp_t got;
    cdq_pkg::rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got = '{pop_value: rsp_ch.pop_value, status: rsp_ch.status,
              occupancy: rsp_ch.occupancy};
      out_count <= out_count + 1;
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, got);
      end else begin
        want = expected_rsp.pop_front();
        if (got.pop_value !== want.pop_value || got.status !== want.status ||
            got.occupancy !== want.occupancy)
          report_mismatch("field mismatch", want, got);
      end
    end
  end

  // Watchdog: any handshake clears it.
  always @(posedge clk) begin : stall_watch
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Directed: refused pops on empty, head wrap on a front push,
  // tail wrap on a back pop of the last entry, fill to full across the wrap,
  // refused pushes both ways, then drain from both ends down to empty.
  // Random: segments biased toward filling, draining or neither, so the
  // queue swings between full and empty many times.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cdq_pkg::word_t fill_vals [8];
    int             seg_len;
    int             push_pct;
    int             n;
    bit             is_push;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = cdq_pkg::REQ_PUSH_FRONT;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;

    fill_vals = '{32'sh8000_0000, '1, '0, 32'sh5555_5555,
                  32'shaaaa_aaaa, 32'sh1, 32'sh7fff_ffff, 32'sh1234_5678};

    add_req(cdq_pkg::REQ_POP_FRONT, $urandom, 1'b0);
    add_req(cdq_pkg::REQ_POP_BACK, $urandom, 1'b0);
    add_req(cdq_pkg::REQ_PUSH_FRONT, 32'sh7fff_ffff, 1'b0);   // head 0 -> last slot
    add_req(cdq_pkg::REQ_POP_BACK, $urandom, 1'b0);           // only entry, tail wraps back
    foreach (fill_vals[i])
      add_req(cdq_pkg::REQ_PUSH_BACK, fill_vals[i], 1'b0);    // tail wraps to 0 on the way
    add_req(cdq_pkg::REQ_PUSH_FRONT, $urandom, 1'b0);         // refused, full
    add_req(cdq_pkg::REQ_PUSH_BACK, $urandom, 1'b0);          // refused, full
    for (int i = 0; i < 8; i++)
      add_req((i % 2 == 0) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_BACK, $urandom, 1'b0);

    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(2))
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      seg_len = $urandom_range(40, 8);
      for (int k = 0; k < seg_len && n < N_RANDOM; k++) begin
        is_push = ($urandom_range(99) < push_pct);
        if (is_push)
          add_req($urandom_range(1) ? cdq_pkg::REQ_PUSH_BACK : cdq_pkg::REQ_PUSH_FRONT,
                  pick_value(), n == 0 || n == DRAIN_AT);
        else
          add_req($urandom_range(1) ? cdq_pkg::REQ_POP_BACK : cdq_pkg::REQ_POP_FRONT,
                  pick_value(), n == 0 || n == DRAIN_AT);
        n++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (in_count == total_items);
    wait (out_count == in_count);
    repeat (8) @(posedge clk);
    if (expected_rsp.size() != 0)
      mismatches++;

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_cell.sv
rtl/cdq_chain.sv
rtl/circular_deque.sv
verif/tb_top.sv
